// ===== sv/vc2sp_pkg.sv =====
// ----------------------------------------------------------------------------
// vc2sp_pkg
// Shared types and constants of the VC-2 slice packet planner.
// ----------------------------------------------------------------------------
package vc2sp_pkg;

  localparam int unsigned CFG_W      = 16;
  localparam int unsigned LEN_BYTE_W = 8;
  localparam int unsigned SUM_W      = 10;
  localparam int unsigned LEN_W      = 27;
  localparam int unsigned BYTES_W    = 32;
  localparam int unsigned IDX_W      = 3;

  localparam logic [CFG_W-1:0]   CFG_MAX16   = 16'hFFFF;
  localparam logic [BYTES_W-1:0] BYTES_MAX   = 32'hFFFF_FFFF;
  localparam logic [LEN_W-1:0]   SLICE_EXTRA = 27'd4;
  localparam logic [BYTES_W+1:0] HEADER_BYTES = 34'd16;

  localparam logic [CFG_W-1:0] RST_MAX_PACKET = 16'd1400;
  localparam logic [CFG_W-1:0] RST_PREFIX     = 16'd0;
  localparam logic [CFG_W-1:0] RST_SCALER     = 16'd1;
  localparam logic [CFG_W-1:0] RST_ACROSS     = 16'd1;
  localparam logic [CFG_W-1:0] RST_DOWN       = 16'd1;

  typedef enum logic [IDX_W-1:0] {
    REG_MAX_PACKET = 3'd0,
    REG_PREFIX     = 3'd1,
    REG_SCALER     = 3'd2,
    REG_ACROSS     = 3'd3,
    REG_DOWN       = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] max_packet_bytes;
    logic [CFG_W-1:0] prefix_bytes;
    logic [CFG_W-1:0] size_scaler;
    logic [CFG_W-1:0] slices_across;
    logic [CFG_W-1:0] slices_down;
  } cfg_t;

  typedef struct packed {
    logic [LEN_BYTE_W-1:0] luma_len_byte;
    logic [LEN_BYTE_W-1:0] chroma1_len_byte;
    logic [LEN_BYTE_W-1:0] chroma2_len_byte;
  } slice_t;

  typedef struct packed {
    logic [BYTES_W-1:0] packet_offset;
    logic [BYTES_W-1:0] packet_bytes;
    logic [CFG_W-1:0]   slice_count;
    logic [CFG_W-1:0]   start_slice_x;
    logic [CFG_W-1:0]   start_slice_y;
    logic               picture_end;
    logic               run_end;
  } packet_t;

  typedef struct packed {
    logic valid;
    logic full;
  } queue_status_t;

endpackage

// ===== sv/vc2sp_slice_if.sv =====
// ----------------------------------------------------------------------------
// vc2sp_slice_if
// Slice request channel: valid, ready and the three component length bytes.
// ----------------------------------------------------------------------------
interface vc2sp_slice_if;
  logic            valid;
  logic            ready;
  vc2sp_pkg::slice_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ===== sv/vc2sp_packet_if.sv =====
// ----------------------------------------------------------------------------
// vc2sp_packet_if
// Packet descriptor request channel: valid, ready and the descriptor.
// ----------------------------------------------------------------------------
interface vc2sp_packet_if;
  logic               valid;
  logic               ready;
  vc2sp_pkg::packet_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ===== sv/vc2sp_front.sv =====
// ----------------------------------------------------------------------------
// vc2sp_front
// Accepts slice requests and computes each slice's byte length.
// ----------------------------------------------------------------------------
module vc2sp_front (
  vc2sp_slice_if.sink                      slice,
  input  vc2sp_pkg::cfg_t                  cfg,
  input  vc2sp_pkg::queue_status_t         qstat,
  output logic                             push,
  output logic [vc2sp_pkg::LEN_W-1:0]      push_len
);

  logic [vc2sp_pkg::SUM_W-1:0]   comp_sum;
  logic [vc2sp_pkg::LEN_W-2:0]   scaled;

  assign comp_sum = {2'b00, slice.item.luma_len_byte}
                  + {2'b00, slice.item.chroma1_len_byte}
                  + {2'b00, slice.item.chroma2_len_byte};

  assign scaled   = cfg.size_scaler * comp_sum;
  assign push_len = {1'b0, scaled}
                  + {11'd0, cfg.prefix_bytes}
                  + vc2sp_pkg::SLICE_EXTRA;

  assign slice.ready = !qstat.full;
  assign push        = slice.valid && !qstat.full;

endmodule

// ===== sv/vc2sp_queue.sv =====
// ----------------------------------------------------------------------------
// vc2sp_queue
// Short FIFO of slice lengths between the front and back parts.
// ----------------------------------------------------------------------------
module vc2sp_queue #(
  parameter int unsigned DEPTH = 4,
  parameter int unsigned WIDTH = 27
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic [WIDTH-1:0]          push_data,
  input  logic                      pop,
  output logic [WIDTH-1:0]          pop_data,
  output vc2sp_pkg::queue_status_t  qstat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign qstat.valid = (count != '0);
  assign qstat.full  = (count == FULL);
  assign pop_data    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> qstat.valid)
    else $error("queue popped while empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full)
    else $error("queue pushed while full");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL)
    else $error("queue count out of range");
`endif

endmodule

// ===== sv/vc2sp_back.sv =====
// ----------------------------------------------------------------------------
// vc2sp_back
// Packs slice lengths into packets and issues packet descriptors.
// ----------------------------------------------------------------------------
module vc2sp_back (
  input  logic                            clk,
  input  logic                            rst,
  input  vc2sp_pkg::cfg_t                 cfg,
  input  vc2sp_pkg::queue_status_t        qstat,
  input  logic [vc2sp_pkg::LEN_W-1:0]     pop_len,
  output logic                            pop,
  vc2sp_packet_if.source                  packet
);

  localparam int unsigned BW = vc2sp_pkg::BYTES_W;
  localparam int unsigned CW = vc2sp_pkg::CFG_W;

  logic [CW-1:0] cur_x;
  logic [CW-1:0] cur_y;
  logic [CW-1:0] open_start_x;
  logic [CW-1:0] open_start_y;
  logic [BW-1:0] open_bytes;
  logic [CW-1:0] open_slices;
  logic [BW-1:0] open_offset;
  logic          pend_final;
  logic          out_valid;
  vc2sp_pkg::packet_t out_pkt;

  logic          can_load;
  logic          take;
  logic [BW:0]   sum_open;
  logic [BW+1:0] fit_sum;
  logic [BW:0]   sum_off;
  logic          close;
  logic [BW-1:0] bytes_sat;
  logic [BW-1:0] off_sat;
  logic [BW-1:0] bytes_next;
  logic [CW-1:0] slices_next;
  logic [BW-1:0] offset_next;
  logic [CW-1:0] start_x_next;
  logic [CW-1:0] start_y_next;
  logic [CW:0]   x_inc;
  logic [CW:0]   y_inc;
  logic          row_end;
  logic          pic_end;
  vc2sp_pkg::packet_t closed_pkt;
  vc2sp_pkg::packet_t final_pkt;
  vc2sp_pkg::packet_t pend_pkt;

  assign can_load = !out_valid || packet.ready;
  assign take     = can_load && !pend_final && qstat.valid;
  assign pop      = take;

  assign sum_open  = {1'b0, open_bytes} + {6'd0, pop_len};
  assign fit_sum   = {1'b0, sum_open} + vc2sp_pkg::HEADER_BYTES;
  assign sum_off   = {1'b0, open_offset} + {1'b0, open_bytes};
  assign close     = (open_slices != '0) && (fit_sum > {18'd0, cfg.max_packet_bytes});
  assign bytes_sat = sum_open[BW] ? vc2sp_pkg::BYTES_MAX : sum_open[BW-1:0];
  assign off_sat   = sum_off[BW] ? vc2sp_pkg::BYTES_MAX : sum_off[BW-1:0];

  assign bytes_next   = close ? {5'd0, pop_len} : bytes_sat;
  assign offset_next  = close ? off_sat : open_offset;
  assign start_x_next = close ? cur_x : open_start_x;
  assign start_y_next = close ? cur_y : open_start_y;
  assign slices_next  = close ? CW'(1)
                      : ((open_slices == vc2sp_pkg::CFG_MAX16) ? open_slices
                                                               : open_slices + 1'b1);

  assign x_inc   = {1'b0, cur_x} + 1'b1;
  assign y_inc   = {1'b0, cur_y} + 1'b1;
  assign row_end = x_inc[CW] || (x_inc[CW-1:0] >= cfg.slices_across);
  assign pic_end = row_end && (y_inc[CW] || (y_inc[CW-1:0] >= cfg.slices_down));

  always_comb begin
    closed_pkt.packet_offset = open_offset;
    closed_pkt.packet_bytes  = open_bytes;
    closed_pkt.slice_count   = open_slices;
    closed_pkt.start_slice_x = open_start_x;
    closed_pkt.start_slice_y = open_start_y;
    closed_pkt.picture_end   = 1'b0;
    closed_pkt.run_end       = !pic_end;

    final_pkt.packet_offset  = offset_next;
    final_pkt.packet_bytes   = bytes_next;
    final_pkt.slice_count    = slices_next;
    final_pkt.start_slice_x  = start_x_next;
    final_pkt.start_slice_y  = start_y_next;
    final_pkt.picture_end    = 1'b1;
    final_pkt.run_end        = 1'b1;

    pend_pkt.packet_offset   = open_offset;
    pend_pkt.packet_bytes    = open_bytes;
    pend_pkt.slice_count     = open_slices;
    pend_pkt.start_slice_x   = open_start_x;
    pend_pkt.start_slice_y   = open_start_y;
    pend_pkt.picture_end     = 1'b1;
    pend_pkt.run_end         = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_pkt <= close ? closed_pkt : final_pkt;
    end else if (can_load && pend_final) begin
      out_pkt <= pend_pkt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x        <= '0;
      cur_y        <= '0;
      open_start_x <= '0;
      open_start_y <= '0;
      open_bytes   <= '0;
      open_slices  <= '0;
      open_offset  <= '0;
      pend_final   <= 1'b0;
      out_valid    <= 1'b0;
    end else if (can_load && pend_final) begin
      cur_x        <= '0;
      cur_y        <= '0;
      open_start_x <= '0;
      open_start_y <= '0;
      open_bytes   <= '0;
      open_slices  <= '0;
      open_offset  <= '0;
      pend_final   <= 1'b0;
      out_valid    <= 1'b1;
    end else if (take) begin
      out_valid <= close || pic_end;
      if (pic_end && !close) begin
        cur_x        <= '0;
        cur_y        <= '0;
        open_start_x <= '0;
        open_start_y <= '0;
        open_bytes   <= '0;
        open_slices  <= '0;
        open_offset  <= '0;
      end else begin
        open_start_x <= start_x_next;
        open_start_y <= start_y_next;
        open_bytes   <= bytes_next;
        open_slices  <= slices_next;
        open_offset  <= offset_next;
        pend_final   <= pic_end;
        if (row_end) begin
          cur_x <= '0;
          cur_y <= y_inc[CW-1:0];
        end else begin
          cur_x <= x_inc[CW-1:0];
        end
      end
    end else if (can_load) begin
      out_valid <= 1'b0;
    end
  end

  assign packet.valid = out_valid;
  assign packet.item  = out_pkt;

`ifndef ASSERT_OFF
  a_pend_holds_out: assert property (@(posedge clk) disable iff (rst)
    pend_final |-> (out_valid && !out_pkt.run_end && !out_pkt.picture_end))
    else $error("pending final packet without closed packet in output");

  a_pic_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_pkt.picture_end) |-> out_pkt.run_end)
    else $error("picture end packet not last of its run");

  a_pic_end_clears: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_pkt.picture_end && !$past(out_valid && packet.ready))
      |-> (open_slices == '0))
    else $error("state not cleared after picture end");

  a_no_empty_packet: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_pkt.slice_count != '0))
    else $error("packet descriptor with no slices");
`endif

endmodule

// ===== sv/vc2_slice_packet_planner.sv =====
// ----------------------------------------------------------------------------
// vc2_slice_packet_planner
// Plans RTP packets for VC-2 HQ pictures from per-slice component lengths.
// ----------------------------------------------------------------------------
// One slice request is taken per clock cycle while the queue is not full.
// Each slice's byte length is computed on entry and queued; the packing stage
// pops one slice a cycle into one descriptor register while it is free, so a
// slice that both closes a packet and ends the picture fills that register
// with two descriptors in turn and stalls packing until the second is loaded.
// A descriptor is registered after its slice is queued. Configuration writes
// take effect at once and should be made only while no slice is in flight.
// ----------------------------------------------------------------------------
module vc2_slice_packet_planner #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [vc2sp_pkg::IDX_W-1:0]        cfg_index,
  input  logic [vc2sp_pkg::CFG_W-1:0]        cfg_data,
  vc2sp_slice_if.sink                        slice,
  vc2sp_packet_if.source                     packet
);

  vc2sp_pkg::cfg_t           cfg;
  vc2sp_pkg::queue_status_t  qstat;
  logic                      push;
  logic                      pop;
  logic [vc2sp_pkg::LEN_W-1:0] push_len;
  logic [vc2sp_pkg::LEN_W-1:0] pop_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_packet_bytes <= vc2sp_pkg::RST_MAX_PACKET;
      cfg.prefix_bytes     <= vc2sp_pkg::RST_PREFIX;
      cfg.size_scaler      <= vc2sp_pkg::RST_SCALER;
      cfg.slices_across    <= vc2sp_pkg::RST_ACROSS;
      cfg.slices_down      <= vc2sp_pkg::RST_DOWN;
    end else if (cfg_we) begin
      case (cfg_index)
        vc2sp_pkg::REG_MAX_PACKET: cfg.max_packet_bytes <= cfg_data;
        vc2sp_pkg::REG_PREFIX:     cfg.prefix_bytes     <= cfg_data;
        vc2sp_pkg::REG_SCALER:     cfg.size_scaler      <= cfg_data;
        vc2sp_pkg::REG_ACROSS:     cfg.slices_across    <= cfg_data;
        vc2sp_pkg::REG_DOWN:       cfg.slices_down      <= cfg_data;
        default: ;
      endcase
    end
  end

  vc2sp_front u_front (
    .slice    (slice),
    .cfg      (cfg),
    .qstat    (qstat),
    .push     (push),
    .push_len (push_len)
  );

  vc2sp_queue #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (vc2sp_pkg::LEN_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_len),
    .pop       (pop),
    .pop_data  (pop_len),
    .qstat     (qstat)
  );

  vc2sp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .qstat   (qstat),
    .pop_len (pop_len),
    .pop     (pop),
    .packet  (packet)
  );

endmodule
